/* hdl/dmwc_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// dmwc_pkg: shared types and constants for the direct-mapped cache controller
// Holds default geometry, counter width, controller states and the command
// and status bundles passed between controller and datapath.
// ============================================================================
package dmwc_pkg;

  localparam int DEF_LINE_COUNT  = 128;
  localparam int DEF_BLOCK_BYTES = 32;
  localparam int DEF_ADDR_WIDTH  = 32;

  // Hit and miss counters wrap at this width.
  localparam int CNT_W = 32;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_LOOKUP
  } dmwc_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;   // latch the reference and start the tag read
    logic resolve;   // compare, update line state, load the result register
  } dmwc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;  // result register empty or being drained this cycle
  } dmwc_status_t;

endpackage

/* hdl/direct_mapped_writeback_cache_ctrl_unit.sv */
`timescale 1ns / 1ps
// ============================================================================
// direct_mapped_writeback_cache_ctrl_unit: direct-mapped write-back cache tags
// Looks up one memory reference per transfer against a direct-mapped tag
// store under write-back, write-allocate rules and reports the actions.
// ============================================================================
// Usage:
//   Slave channel s_*: one reference per transfer. s_tdata carries the byte
//   address, s_tuser the access kind (0 read, 1 write).
//   Master channel m_*: one result per reference, in order: address split,
//   miss, fill and write-back requests, replacement with evicted tag, and
//   the wrapping hit and miss counters after this reference.
//   Sequence: a reference is captured and its tag read is registered; then
//   the compare-and-update step loads its result into the output register
//   once the master side is free. A new reference is taken only after the
//   last one is resolved: the tag read and the update act on the same line.
//   Stall: the result sits in an output register; the next reference is
//   taken and its tag read is started, and its resolve waits until the
//   waiting result is transferred.
//   Reset (rst, synchronous): clears all valid and dirty bits, both counters
//   and the output valid at once; no clearing pass. Tag memory is not reset.
// ============================================================================
module direct_mapped_writeback_cache_ctrl_unit #(
  parameter int LINE_COUNT  = dmwc_pkg::DEF_LINE_COUNT,
  parameter int BLOCK_BYTES = dmwc_pkg::DEF_BLOCK_BYTES,
  parameter int ADDR_WIDTH  = dmwc_pkg::DEF_ADDR_WIDTH,
  localparam int OFF_W  = $clog2(BLOCK_BYTES),
  localparam int IDX_W  = $clog2(LINE_COUNT),
  localparam int BLK_W  = ADDR_WIDTH - OFF_W,
  localparam int TAG_W  = ADDR_WIDTH - OFF_W - IDX_W,
  localparam int OUT_W  = OFF_W + BLK_W + IDX_W + 2 * TAG_W + 4 + 2 * dmwc_pkg::CNT_W,
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8,
  localparam int IN_TW  = ((ADDR_WIDTH + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_TW-1:0]  s_tdata,   // address
  input  logic              s_tuser,   // func
  output logic              m_tvalid,
  input  logic              m_tready,
  // byte_offset, block_number, line_index, tag_value, is_miss, fill_request,
  // writeback_request, replaced, evicted_tag, hits_so_far, misses_so_far
  output logic [OUT_TW-1:0] m_tdata
);

  dmwc_pkg::dmwc_cmd_t    cmd;
  dmwc_pkg::dmwc_status_t status;

  dmwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Padding bits of s_tdata above the address are ignored.
  dmwc_datapath #(
    .LINE_COUNT  (LINE_COUNT),
    .BLOCK_BYTES (BLOCK_BYTES),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_address (s_tdata[ADDR_WIDTH-1:0]),
    .in_func    (s_tuser),
    .cmd        (cmd),
    .status     (status),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

/* hdl/dmwc_ctrl.sv */
`timescale 1ns / 1ps
// ============================================================================
// dmwc_ctrl: lookup sequencer
// Takes a reference in idle, then resolves it once the result register has
// room, and returns to idle.
// ============================================================================
module dmwc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  dmwc_pkg::dmwc_status_t status,
  output dmwc_pkg::dmwc_cmd_t    cmd
);

  dmwc_pkg::dmwc_state_t state;
  dmwc_pkg::dmwc_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmwc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.resolve = 1'b0;
    case (state)
      dmwc_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = dmwc_pkg::ST_LOOKUP;
        end
      end
      dmwc_pkg::ST_LOOKUP: begin
        // hold here while the previous result still waits downstream
        if (status.out_free) begin
          cmd.resolve = 1'b1;
          state_next  = dmwc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dmwc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/dmwc_datapath.sv */
`timescale 1ns / 1ps
// ============================================================================
// dmwc_datapath: tag memory, line state, counters and result register
// Splits the address, compares against the stored tag, applies write-back,
// write-allocate updates and packs the result transfer.
// ============================================================================
module dmwc_datapath #(
  parameter int LINE_COUNT  = dmwc_pkg::DEF_LINE_COUNT,
  parameter int BLOCK_BYTES = dmwc_pkg::DEF_BLOCK_BYTES,
  parameter int ADDR_WIDTH  = dmwc_pkg::DEF_ADDR_WIDTH,
  localparam int OFF_W  = $clog2(BLOCK_BYTES),
  localparam int IDX_W  = $clog2(LINE_COUNT),
  localparam int BLK_W  = ADDR_WIDTH - OFF_W,
  localparam int TAG_W  = ADDR_WIDTH - OFF_W - IDX_W,
  localparam int OUT_W  = OFF_W + BLK_W + IDX_W + 2 * TAG_W + 4 + 2 * dmwc_pkg::CNT_W,
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [ADDR_WIDTH-1:0]  in_address,
  input  logic                   in_func,
  input  dmwc_pkg::dmwc_cmd_t    cmd,
  output dmwc_pkg::dmwc_status_t status,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TW-1:0]      m_tdata
);

  logic [TAG_W-1:0]      tag_mem [LINE_COUNT];
  logic [LINE_COUNT-1:0] valid_bits;
  logic [LINE_COUNT-1:0] dirty_bits;

  logic [ADDR_WIDTH-1:0] addr_q;
  logic                  wr_q;
  logic [TAG_W-1:0]      tag_rd;

  logic [dmwc_pkg::CNT_W-1:0] hit_cnt;
  logic [dmwc_pkg::CNT_W-1:0] miss_cnt;
  logic [dmwc_pkg::CNT_W-1:0] hit_cnt_next;
  logic [dmwc_pkg::CNT_W-1:0] miss_cnt_next;

  logic [OFF_W-1:0] offs;
  logic [BLK_W-1:0] blk;
  logic [IDX_W-1:0] idx;
  logic [TAG_W-1:0] tag;
  logic [IDX_W-1:0] in_idx;
  logic             line_valid;
  logic             line_dirty;
  logic             miss;
  logic             wback;
  logic             repl;
  logic [TAG_W-1:0] ev_tag;
  logic [OUT_W-1:0] result;

  assign in_idx = in_address[OFF_W +: IDX_W];

  assign offs = addr_q[OFF_W-1:0];
  assign blk  = addr_q[ADDR_WIDTH-1:OFF_W];
  assign idx  = addr_q[OFF_W +: IDX_W];
  assign tag  = addr_q[ADDR_WIDTH-1:OFF_W+IDX_W];

  assign line_valid = valid_bits[idx];
  assign line_dirty = dirty_bits[idx];
  assign miss       = !(line_valid && (tag_rd == tag));
  assign wback      = miss && line_dirty;
  assign repl       = miss && line_valid;
  assign ev_tag     = repl ? tag_rd : '0;

  assign hit_cnt_next  = miss ? hit_cnt : hit_cnt + 1'b1;
  assign miss_cnt_next = miss ? miss_cnt + 1'b1 : miss_cnt;

  assign result = {miss_cnt_next, hit_cnt_next, ev_tag, repl, wback, miss, miss,
                   tag, idx, blk, offs};

  assign status.out_free = !m_tvalid || m_tready;

  // Tag memory: read on capture, written on a miss.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tag_rd <= tag_mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve && miss) begin
      tag_mem[idx] <= tag;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_q <= in_address;
      wr_q   <= in_func;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      dirty_bits <= '0;
      hit_cnt    <= '0;
      miss_cnt   <= '0;
    end else if (cmd.resolve) begin
      valid_bits[idx] <= 1'b1;
      // a read miss on a valid line leaves the new copy clean
      if (wr_q) begin
        dirty_bits[idx] <= 1'b1;
      end else if (repl) begin
        dirty_bits[idx] <= 1'b0;
      end
      hit_cnt  <= hit_cnt_next;
      miss_cnt <= miss_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.resolve) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      m_tdata <= {{(OUT_TW - OUT_W){1'b0}}, result};
    end
  end

  // Every resolved reference counts exactly once.
  a_count_once: assert property (@(posedge clk) disable iff (rst)
    cmd.resolve |=> (hit_cnt + miss_cnt) == $past(hit_cnt + miss_cnt) + 1'b1)
    else $error("hit plus miss count did not advance by one");

  // A write-back or a replacement only ever comes with a miss.
  a_wb_repl_miss: assert property (@(posedge clk) disable iff (rst)
    cmd.resolve && (wback || repl) |-> miss)
    else $error("write-back or replacement reported on a hit");

  // A result never overwrites one that is still waiting.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.resolve |-> (!m_tvalid || m_tready))
    else $error("result register overrun");

  // The line just resolved is valid afterwards.
  a_line_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.resolve |=> valid_bits[$past(idx)])
    else $error("resolved line not marked valid");

endmodule
